>>> hdl/pcc_pkg.sv
// ---------------------------------------------------------------------------
// pcc_pkg: shared types and constants
// Command codes, configuration register indexes and the packed transaction
// types of the pairwise concordance counter.
// ---------------------------------------------------------------------------
package pcc_pkg;

    localparam int COORD_W   = 32;
    localparam int COUNT_W   = 8;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 9;
    localparam int NP_W      = 9;
    localparam int NC_W      = 4;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLUMNS = 2'd1;

    localparam logic [NP_W-1:0] NP_RESET = 9'd256;
    localparam logic [NC_W-1:0] NC_RESET = 4'd2;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic [7:0]                point;
        logic [2:0]                column;
        logic signed [COORD_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [COUNT_W-1:0] concordant_count;
        logic               pass_done;
    } t_out;

endpackage

>>> hdl/pcc_coord_ram.sv
// ---------------------------------------------------------------------------
// pcc_coord_ram: coordinate store
// One write port, two registered read ports, one coordinate per entry.
// ---------------------------------------------------------------------------
module pcc_coord_ram #(
    parameter int AW = 11
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [pcc_pkg::COORD_W-1:0] i_wdata,
    input  logic [AW-1:0]               i_raddr_a,
    input  logic [AW-1:0]               i_raddr_b,
    output logic [pcc_pkg::COORD_W-1:0] o_rdata_a,
    output logic [pcc_pkg::COORD_W-1:0] o_rdata_b
);

    logic [pcc_pkg::COORD_W-1:0] mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

>>> hdl/pcc_disc_ram.sv
// ---------------------------------------------------------------------------
// pcc_disc_ram: discordance counter store
// One row per point holding all level counters; one write port and one
// registered read port that holds its data while not enabled.
// ---------------------------------------------------------------------------
module pcc_disc_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 56
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

>>> hdl/pairwise_concordance_counter_core.sv
// ---------------------------------------------------------------------------
// pairwise_concordance_counter_core: brute-force concordance counter
// Load: no result. Read: issues the row, sums the counters up to the level, then strobes.
// Start: clears the counter store, then per pair issues and compares each
//   column in turn, column 0 included (one shared signed comparator), then
//   steps to the next pair, through bump states A, B and W when the pair
//   bumps its counters; done strobe follows the last pair.
// Reset: clears the counter store with busy high.
// Results are strobed for one cycle; the receiver cannot stall.
// ---------------------------------------------------------------------------
module pairwise_concordance_counter_core #(
    parameter int MAX_POINTS  = 256,
    parameter int MAX_COLUMNS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  pcc_pkg::t_in                      i_in,
    output logic                              o_res_strobe,
    output pcc_pkg::t_out                     o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pcc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pcc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int LEVELS = MAX_COLUMNS - 1;
    localparam int PW     = $clog2(MAX_POINTS);
    localparam int CW     = $clog2(MAX_COLUMNS);
    localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int NW     = (PW + 1 > pcc_pkg::NP_W) ? PW + 1 : pcc_pkg::NP_W;
    localparam int SW     = $clog2(LEVELS * 255 + 1);
    localparam int AW     = (SW > NW) ? SW : NW;
    localparam int RW     = LEVELS * pcc_pkg::COUNT_W;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_CLEAR    = 11'b000_0000_0010,
        S_ISSUE    = 11'b000_0000_0100,
        S_CMP      = 11'b000_0000_1000,
        S_BUMP_A   = 11'b000_0001_0000,
        S_BUMP_B   = 11'b000_0010_0000,
        S_BUMP_W   = 11'b000_0100_0000,
        S_NEXT     = 11'b000_1000_0000,
        S_RD_ISSUE = 11'b001_0000_0000,
        S_RD_SUM   = 11'b010_0000_0000,
        S_RD_OUT   = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic [pcc_pkg::NP_W-1:0] r_np;
    logic [pcc_pkg::NC_W-1:0] r_nc;
    logic [PW-1:0] r_a, n_a, r_b, n_b, r_clr, n_clr, r_pt, n_pt;
    logic [CW-1:0] r_c, n_c;
    logic [LW-1:0] r_lvl, n_lvl, r_l, n_l;
    logic          r_swap, n_swap, r_pass, n_pass, r_strobe, n_strobe;
    logic [SW-1:0] r_sum, n_sum;
    pcc_pkg::t_out r_out, n_out;

    logic [NW-1:0] n_eff;
    logic [CW-1:0] dm1;
    logic          accept;
    logic [pcc_pkg::COORD_W-1:0] q_a, q_b, cmp_x, cmp_y;
    logic          gt;
    logic          coord_we;
    logic [PW+CW-1:0] coord_waddr;
    logic          disc_we, disc_re;
    logic [PW-1:0] disc_waddr, disc_raddr;
    logic [RW-1:0] disc_wdata, disc_q;
    logic [AW-1:0] nm1, sum_ext, res;

    function automatic logic [RW-1:0] bump_row(input logic [RW-1:0] row,
                                               input logic [LW-1:0] lvl);
        logic [RW-1:0] r;
        logic [pcc_pkg::COUNT_W-1:0] cnt;
        r   = row;
        cnt = row[pcc_pkg::COUNT_W*lvl +: pcc_pkg::COUNT_W];
        if (cnt != '1) begin
            r[pcc_pkg::COUNT_W*lvl +: pcc_pkg::COUNT_W] = cnt + 1'b1;
        end
        return r;
    endfunction

    assign busy         = (r_state != S_IDLE);
    assign accept       = start && !busy;
    assign o_cfg_ready  = 1'b1;
    assign o_res_strobe = r_strobe;
    assign o_out        = r_out;

    // effective point count and last column index after clamping
    always_comb begin
        if (r_np < 9'd2) begin
            n_eff = NW'(2);
        end else if (32'(r_np) > 32'(MAX_POINTS)) begin
            n_eff = NW'(MAX_POINTS);
        end else begin
            n_eff = NW'(r_np);
        end
        if (r_nc < 4'd2) begin
            dm1 = CW'(1);
        end else if (32'(r_nc) > 32'(MAX_COLUMNS)) begin
            dm1 = CW'(MAX_COLUMNS - 1);
        end else begin
            dm1 = CW'(r_nc - 4'd1);
        end
    end

    // coordinate store
    assign coord_we = accept && (i_in.cmd == pcc_pkg::CMD_LOAD)
                      && (32'(i_in.point) < 32'(MAX_POINTS))
                      && (32'(i_in.column) < 32'(MAX_COLUMNS));
    assign coord_waddr = {PW'(i_in.point), CW'(i_in.column)};

    pcc_coord_ram #(
        .AW(PW + CW)
    ) u_coord (
        .i_clk     (i_clk),
        .i_we      (coord_we),
        .i_waddr   (coord_waddr),
        .i_wdata   (i_in.value),
        .i_raddr_a ({r_a, r_c}),
        .i_raddr_b ({r_b, r_c}),
        .o_rdata_a (q_a),
        .o_rdata_b (q_b)
    );

    // shared comparator: column 0 picks the order, later columns test it
    assign cmp_x = (r_swap && (r_c != '0)) ? q_b : q_a;
    assign cmp_y = (r_swap && (r_c != '0)) ? q_a : q_b;
    assign gt    = $signed(cmp_x) > $signed(cmp_y);

    // counter store
    always_comb begin
        disc_re    = (r_state == S_BUMP_A) || (r_state == S_BUMP_B)
                     || (r_state == S_RD_ISSUE);
        disc_we    = (r_state == S_CLEAR) || (r_state == S_BUMP_B)
                     || (r_state == S_BUMP_W);
        disc_raddr = r_pt;
        if (r_state == S_BUMP_A) begin
            disc_raddr = r_a;
        end else if (r_state == S_BUMP_B) begin
            disc_raddr = r_b;
        end
        disc_waddr = (r_state == S_CLEAR) ? r_clr :
                     (r_state == S_BUMP_B) ? r_a : r_b;
        disc_wdata = (r_state == S_CLEAR) ? '0 : bump_row(disc_q, r_lvl);
    end

    pcc_disc_ram #(
        .DEPTH (MAX_POINTS),
        .AW    (PW),
        .DW    (RW)
    ) u_disc (
        .i_clk   (i_clk),
        .i_we    (disc_we),
        .i_waddr (disc_waddr),
        .i_wdata (disc_wdata),
        .i_re    (disc_re),
        .i_raddr (disc_raddr),
        .o_rdata (disc_q)
    );

    // read answer: n-1 minus the level sum, floored at 0, capped at 255
    always_comb begin
        nm1     = AW'(n_eff) - AW'(1);
        sum_ext = AW'(r_sum);
        res     = (sum_ext >= nm1) ? '0 : nm1 - sum_ext;
    end

    always_comb begin
        n_state  = r_state;
        n_a      = r_a;
        n_b      = r_b;
        n_c      = r_c;
        n_clr    = r_clr;
        n_pt     = r_pt;
        n_lvl    = r_lvl;
        n_l      = r_l;
        n_swap   = r_swap;
        n_pass   = r_pass;
        n_sum    = r_sum;
        n_out    = r_out;
        n_strobe = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in.cmd)
                        pcc_pkg::CMD_START: begin
                            n_state = S_CLEAR;
                            n_pass  = 1'b1;
                            n_clr   = '0;
                        end
                        pcc_pkg::CMD_READ: begin
                            if (32'(i_in.point) < 32'(MAX_POINTS)) begin
                                n_pt    = PW'(i_in.point);
                                n_state = S_RD_ISSUE;
                                if (32'(i_in.column) > 32'(dm1 - CW'(1))) begin
                                    n_lvl = LW'(dm1 - CW'(1));
                                end else begin
                                    n_lvl = LW'(i_in.column);
                                end
                            end else begin
                                n_out.concordant_count = '0;
                                n_out.pass_done        = 1'b0;
                                n_strobe               = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == PW'(MAX_POINTS - 1)) begin
                    n_state = r_pass ? S_ISSUE : S_IDLE;
                    n_pass  = 1'b0;
                    n_a     = '0;
                    n_b     = PW'(1);
                    n_c     = '0;
                end
            end
            S_ISSUE: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_c == '0) begin
                    n_swap  = gt;
                    n_c     = CW'(1);
                    n_state = S_ISSUE;
                end else if (gt) begin
                    n_lvl   = LW'(r_c - CW'(1));
                    n_state = S_BUMP_A;
                end else if (r_c == dm1) begin
                    n_state = S_NEXT;
                end else begin
                    n_c     = r_c + 1'b1;
                    n_state = S_ISSUE;
                end
            end
            S_BUMP_A: begin
                n_state = S_BUMP_B;
            end
            S_BUMP_B: begin
                n_state = S_BUMP_W;
            end
            S_BUMP_W: begin
                n_state = S_NEXT;
            end
            S_NEXT: begin
                n_c = '0;
                if (NW'(r_b) + NW'(1) == n_eff) begin
                    if (NW'(r_a) + NW'(2) == n_eff) begin
                        n_out.concordant_count = '0;
                        n_out.pass_done        = 1'b1;
                        n_strobe               = 1'b1;
                        n_state                = S_IDLE;
                    end else begin
                        n_a     = r_a + 1'b1;
                        n_b     = r_a + PW'(2);
                        n_state = S_ISSUE;
                    end
                end else begin
                    n_b     = r_b + 1'b1;
                    n_state = S_ISSUE;
                end
            end
            S_RD_ISSUE: begin
                n_sum   = '0;
                n_l     = '0;
                n_state = S_RD_SUM;
            end
            S_RD_SUM: begin
                n_sum = r_sum + SW'(disc_q[pcc_pkg::COUNT_W*r_l +: pcc_pkg::COUNT_W]);
                if (r_l == r_lvl) begin
                    n_state = S_RD_OUT;
                end else begin
                    n_l = r_l + 1'b1;
                end
            end
            S_RD_OUT: begin
                n_out.concordant_count = (res > AW'(255)) ? 8'hFF : res[7:0];
                n_out.pass_done        = 1'b0;
                n_strobe               = 1'b1;
                n_state                = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_pass   <= 1'b0;
            r_strobe <= 1'b0;
            r_np     <= pcc_pkg::NP_RESET;
            r_nc     <= pcc_pkg::NC_RESET;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_pass   <= n_pass;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    pcc_pkg::CFG_NUM_POINTS:  r_np <= i_cfg_data[pcc_pkg::NP_W-1:0];
                    pcc_pkg::CFG_NUM_COLUMNS: r_nc <= i_cfg_data[pcc_pkg::NC_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_b    <= n_b;
        r_c    <= n_c;
        r_pt   <= n_pt;
        r_lvl  <= n_lvl;
        r_l    <= n_l;
        r_swap <= n_swap;
        r_sum  <= n_sum;
        r_out  <= n_out;
    end

endmodule

>>> sim/tb_pairwise_concordance_counter_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_pairwise_concordance_counter_core: self-checking testbench
// Loads coordinate sets, runs counting passes and reads back concordant
// counts under random idle gaps and several register settings. Each result is
// checked against a testbench predictor of the pass or a fixed directed answer.
// ---------------------------------------------------------------------------
module tb_pairwise_concordance_counter_core;

    localparam int NPTS           = 256;
    localparam int NCOLS          = 8;
    localparam int NLVLS          = NCOLS - 1;
    localparam int WATCHDOG_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int MAX_REPORTS    = 10;
    localparam int ITEM_TARGET    = 1020;
    localparam int MAX_PASS_PTS   = 40;

    localparam logic [pcc_pkg::CMD_W-1:0]     CMD_UNUSED      = 2'd3;
    localparam logic [pcc_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 2'd2;
    localparam logic [pcc_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 2'd3;

    localparam logic signed [pcc_pkg::COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [pcc_pkg::COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    typedef struct {
        bit                             is_cfg;
        logic [pcc_pkg::CFG_IDX_W-1:0]  cfg_index;
        logic [pcc_pkg::CFG_DATA_W-1:0] cfg_data;
        pcc_pkg::t_in                   item;
        bit                             typed;
        pcc_pkg::t_out                  answer;
    } t_dir_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    pcc_pkg::t_in                   i_in;
    logic                           o_res_strobe;
    pcc_pkg::t_out                  o_out;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [pcc_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [pcc_pkg::CFG_DATA_W-1:0] i_cfg_data;

    pairwise_concordance_counter_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_in         (i_in),
        .o_res_strobe (o_res_strobe),
        .o_out        (o_out),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // predictor state
    logic signed [pcc_pkg::COORD_W-1:0] coord_mem   [NPTS][NCOLS];
    bit                                 loaded      [NPTS][NCOLS];
    bit [pcc_pkg::COUNT_W-1:0]          discord_cnt [NPTS][NLVLS];
    bit [pcc_pkg::NP_W-1:0]             np_reg;
    bit [pcc_pkg::NC_W-1:0]             nc_reg;

    pcc_pkg::t_out awaited_answers[$];
    t_dir_row      dir_table[$];
    int            mismatches;
    int            idle_cycles;
    int            items_sent;
    int            quiet_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int eff_points();
        int n;
        n = np_reg;
        if (n < 2) n = 2;
        if (n > NPTS) n = NPTS;
        return n;
    endfunction

    function automatic int eff_columns();
        int d;
        d = nc_reg;
        if (d < 2) d = 2;
        if (d > NCOLS) d = NCOLS;
        return d;
    endfunction

    function automatic void bump(int p, int lvl);
        if (discord_cnt[p][lvl] != 8'hFF) discord_cnt[p][lvl] = discord_cnt[p][lvl] + 1'b1;
    endfunction

    // one full pass: first discordant column per ordered pair
    function automatic void count_discords();
        int  n, d, first, second, k;
        bit  hit;
        n = eff_points();
        d = eff_columns();
        foreach (discord_cnt[p, l]) discord_cnt[p][l] = '0;
        for (int a = 0; a < n - 1; a++) begin
            for (int b = a + 1; b < n; b++) begin
                first  = a;
                second = b;
                if (coord_mem[a][0] > coord_mem[b][0]) begin
                    first  = b;
                    second = a;
                end
                hit = 1'b0;
                for (k = 1; k < d && !hit; k++) begin
                    if (coord_mem[first][k] > coord_mem[second][k]) begin
                        bump(first, k - 1);
                        bump(second, k - 1);
                        hit = 1'b1;
                    end
                end
            end
        end
    endfunction

    function automatic pcc_pkg::t_out concordant_answer(int pt, int lvl);
        pcc_pkg::t_out ans;
        int            n, d, sum, res;
        n   = eff_points();
        d   = eff_columns();
        sum = 0;
        if (lvl > d - 2) lvl = d - 2;
        for (int l = 0; l <= lvl; l++) sum += discord_cnt[pt][l];
        res = (sum >= n - 1) ? 0 : n - 1 - sum;
        if (res > 255) res = 255;
        ans.concordant_count = res[pcc_pkg::COUNT_W-1:0];
        ans.pass_done        = 1'b0;
        return ans;
    endfunction

    function automatic bit predict_item(input pcc_pkg::t_in it, output pcc_pkg::t_out ans);
        ans = '0;
        case (it.cmd)
            pcc_pkg::CMD_LOAD: begin
                coord_mem[it.point][it.column] = it.value;
                loaded[it.point][it.column]    = 1'b1;
                return 1'b0;
            end
            pcc_pkg::CMD_START: begin
                count_discords();
                ans.pass_done = 1'b1;
                return 1'b1;
            end
            pcc_pkg::CMD_READ: begin
                ans = concordant_answer(it.point, it.column);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic pcc_pkg::t_in mk_item(logic [pcc_pkg::CMD_W-1:0] cmd, logic [7:0] pt,
                                             logic [2:0] col,
                                             logic [pcc_pkg::COORD_W-1:0] val);
        pcc_pkg::t_in it;
        it.cmd    = cmd;
        it.point  = pt;
        it.column = col;
        it.value  = val;
        return it;
    endfunction

    function automatic t_dir_row item_row(logic [pcc_pkg::CMD_W-1:0] cmd, logic [7:0] pt,
                                          logic [2:0] col, logic [pcc_pkg::COORD_W-1:0] val,
                                          bit typed = 1'b0, logic [7:0] cnt = '0,
                                          logic done = 1'b0);
        t_dir_row r;
        r = '{default: '0};
        r.item                    = mk_item(cmd, pt, col, val);
        r.typed                   = typed;
        r.answer.concordant_count = cnt;
        r.answer.pass_done        = done;
        return r;
    endfunction

    function automatic t_dir_row cfg_row(logic [pcc_pkg::CFG_IDX_W-1:0] idx,
                                         logic [pcc_pkg::CFG_DATA_W-1:0] data);
        t_dir_row r;
        r = '{default: '0};
        r.is_cfg    = 1'b1;
        r.cfg_index = idx;
        r.cfg_data  = data;
        return r;
    endfunction

    function automatic void add_row(t_dir_row r);
        dir_table = {dir_table, r};
    endfunction

    // extremes, small values for ties, full random
    function automatic logic [pcc_pkg::COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 3))
                    0: return COORD_MAX;
                    1: return COORD_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            1, 2: return $urandom_range(0, 6) - 3;
            default: return $urandom;
        endcase
    endfunction

    function automatic int draw_gap();
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) quiet_left = $urandom_range(10, 40);
        return $urandom_range(0, 13);
    endfunction

    task automatic send_item(input pcc_pkg::t_in it, input bit typed,
                             input pcc_pkg::t_out typed_ans);
        pcc_pkg::t_out ans;
        bit            has_ans;
        int            gap;
        gap = draw_gap();
        @(negedge i_clk);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_in  <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        has_ans = predict_item(it, ans);
        if (has_ans) awaited_answers = {awaited_answers, (typed ? typed_ans : ans)};
        if (it.cmd != CMD_UNUSED) items_sent++;
    endtask

    // drop start, drain all results, then let trailing loads settle
    task automatic quiesce();
        @(negedge i_clk);
        start <= 1'b0;
        while (awaited_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [pcc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pcc_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        repeat ($urandom_range(0, 13)) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            pcc_pkg::CFG_NUM_POINTS:  np_reg = data[pcc_pkg::NP_W-1:0];
            pcc_pkg::CFG_NUM_COLUMNS: nc_reg = data[pcc_pkg::NC_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input int n_raw, input int d_raw);
        logic [pcc_pkg::CFG_DATA_W-1:0] np_data, nc_data;
        np_data = n_raw[pcc_pkg::CFG_DATA_W-1:0];
        nc_data = {5'($urandom_range(0, 31)), 4'(d_raw)};
        quiesce();
        if ($urandom_range(0, 1)) begin
            cfg_write(pcc_pkg::CFG_NUM_POINTS, np_data);
            cfg_write(pcc_pkg::CFG_NUM_COLUMNS, nc_data);
        end else begin
            cfg_write(pcc_pkg::CFG_NUM_COLUMNS, nc_data);
            cfg_write(pcc_pkg::CFG_NUM_POINTS, np_data);
        end
        if ($urandom_range(0, 7) == 0)
            cfg_write($urandom_range(0, 1) ? CFG_UNMAPPED_LO : CFG_UNMAPPED_HI, 9'($urandom));
    endtask

    task automatic send_noise();
        if ($urandom_range(0, 1))
            send_item(mk_item(CMD_UNUSED, 8'($urandom), 3'($urandom), $urandom), 1'b0, '0);
        else
            send_item(mk_item(pcc_pkg::CMD_LOAD, 8'($urandom_range(0, 255)),
                              3'($urandom_range(0, 7)), rand_coord()), 1'b0, '0);
    endtask

    task automatic send_read(input int n);
        int pt;
        pt = ($urandom_range(0, 3) != 0) ? $urandom_range(0, n - 1) : $urandom_range(0, 255);
        send_item(mk_item(pcc_pkg::CMD_READ, 8'(pt), 3'($urandom_range(0, 7)), $urandom),
                  1'b0, '0);
    endtask

    task automatic random_phase(input int phase_no);
        int n_raw, d_raw, n, d;
        case (phase_no)
            0: begin n_raw = 2;   d_raw = 8;  end
            1: begin n_raw = 511; d_raw = 15; end
            2: begin n_raw = 0;   d_raw = 0;  end
            3: begin n_raw = 1;   d_raw = 9;  end
            default: begin
                case ($urandom_range(0, 9))
                    0: n_raw = $urandom_range(0, 1);
                    1: n_raw = $urandom_range(257, 511);
                    2: n_raw = $urandom_range(17, MAX_PASS_PTS);
                    default: n_raw = $urandom_range(2, 16);
                endcase
                d_raw = $urandom_range(0, 15);
            end
        endcase
        set_config(n_raw, d_raw);
        n = eff_points();
        d = eff_columns();
        // stale reads ahead of the new pass
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_read(n);
        if (n <= MAX_PASS_PTS) begin
            for (int p = 0; p < n; p++) begin
                for (int c = 0; c < d; c++) begin
                    if (!loaded[p][c] || $urandom_range(0, 1))
                        send_item(mk_item(pcc_pkg::CMD_LOAD, 8'(p), 3'(c), rand_coord()),
                                  1'b0, '0);
                    if ($urandom_range(0, 9) == 0) send_noise();
                end
            end
            send_item(mk_item(pcc_pkg::CMD_START, 8'($urandom), 3'($urandom), $urandom),
                      1'b0, '0);
            if ($urandom_range(0, 5) == 0)
                send_item(mk_item(pcc_pkg::CMD_START, 8'($urandom), 3'($urandom), $urandom),
                          1'b0, '0);
        end
        repeat ($urandom_range(5, 25)) begin
            send_read(n);
            if ($urandom_range(0, 9) == 0) send_noise();
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        pcc_pkg::t_out exp_ans;
        if (i_rst_n && o_res_strobe) begin
            if (awaited_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result count=%0d done=%0b", $realtime,
                             o_out.concordant_count, o_out.pass_done);
            end else begin
                exp_ans = awaited_answers.pop_front();
                if (o_out.concordant_count !== exp_ans.concordant_count ||
                    o_out.pass_done !== exp_ans.pass_done) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: mismatch count exp=%0d got=%0d, done exp=%0b got=%0b",
                                 $realtime, exp_ans.concordant_count, o_out.concordant_count,
                                 exp_ans.pass_done, o_out.pass_done);
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || (i_cfg_valid && o_cfg_ready) || o_res_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        int phase_no;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_in        = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        mismatches  = 0;
        idle_cycles = 0;
        items_sent  = 0;
        quiet_left  = 0;
        np_reg      = pcc_pkg::NP_RESET;
        nc_reg      = pcc_pkg::NC_RESET;
        foreach (coord_mem[p, c]) begin
            coord_mem[p][c] = '0;
            loaded[p][c]    = 1'b0;
        end
        foreach (discord_cnt[p, l]) discord_cnt[p][l] = '0;

        // reset state: all counters zero, n = 256
        add_row(item_row(pcc_pkg::CMD_READ, 0, 0, 0, 1'b1, 8'd255, 1'b0));
        add_row(item_row(pcc_pkg::CMD_READ, 255, 7, COORD_MAX, 1'b1, 8'd255, 1'b0));
        add_row(item_row(CMD_UNUSED, 255, 7, '1));
        add_row(item_row(pcc_pkg::CMD_LOAD, 255, 7, COORD_MIN));
        add_row(cfg_row(pcc_pkg::CFG_NUM_POINTS, 9'd3));
        add_row(cfg_row(pcc_pkg::CFG_NUM_COLUMNS, 9'd3));
        // tie on column 0 between points 0 and 1; extremes elsewhere
        add_row(item_row(pcc_pkg::CMD_LOAD, 0, 0, 0));
        add_row(item_row(pcc_pkg::CMD_LOAD, 0, 1, COORD_MAX));
        add_row(item_row(pcc_pkg::CMD_LOAD, 0, 2, COORD_MIN));
        add_row(item_row(pcc_pkg::CMD_LOAD, 1, 0, 0));
        add_row(item_row(pcc_pkg::CMD_LOAD, 1, 1, COORD_MIN));
        add_row(item_row(pcc_pkg::CMD_LOAD, 1, 2, COORD_MAX));
        add_row(item_row(pcc_pkg::CMD_LOAD, 2, 0, COORD_MIN));
        add_row(item_row(pcc_pkg::CMD_LOAD, 2, 1, '1));
        add_row(item_row(pcc_pkg::CMD_LOAD, 2, 2, '1));
        add_row(item_row(pcc_pkg::CMD_START, 0, 0, 0, 1'b1, 8'd0, 1'b1));
        add_row(item_row(pcc_pkg::CMD_READ, 0, 0, 0));
        add_row(item_row(pcc_pkg::CMD_READ, 1, 1, 0));
        add_row(item_row(pcc_pkg::CMD_READ, 2, 7, 0));
        add_row(item_row(pcc_pkg::CMD_READ, 200, 0, 0));
        // read follows the current point count, not the one of the pass
        add_row(cfg_row(pcc_pkg::CFG_NUM_POINTS, 9'd200));
        add_row(item_row(pcc_pkg::CMD_READ, 0, 1, 0));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_table[i]) begin
            if (dir_table[i].is_cfg) begin
                quiesce();
                cfg_write(dir_table[i].cfg_index, dir_table[i].cfg_data);
            end else begin
                send_item(dir_table[i].item, dir_table[i].typed, dir_table[i].answer);
            end
        end

        // one pass at full size with two columns
        set_config(NPTS, 2);
        for (int p = 0; p < NPTS; p++)
            for (int c = 0; c < 2; c++)
                send_item(mk_item(pcc_pkg::CMD_LOAD, 8'(p), 3'(c), rand_coord()), 1'b0, '0);
        send_item(mk_item(pcc_pkg::CMD_START, 8'($urandom), 3'($urandom), $urandom),
                  1'b0, '0);
        repeat (30) send_read(NPTS);

        phase_no = 0;
        while (items_sent < ITEM_TARGET) begin
            random_phase(phase_no);
            phase_no++;
        end

        quiesce();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
